// ===== rtl/plpd_pkg.sv =====
// ----------------------------------------------------------------------------
// plpd_pkg
// Shared type for the point to line projection and distance pipeline.
// ----------------------------------------------------------------------------
package plpd_pkg;

  // Stage control that every pipeline section receives from the top level.
  typedef struct packed {
    logic en;     // whole pipeline advances by one stage
    logic valid;  // an item enters the first stage of the section
  } pipe_ctl_t;

endpackage

// ===== rtl/point_line_projection_distance_top.sv =====
// ----------------------------------------------------------------------------
// point_line_projection_distance_top
// Perpendicular foot position along line AB and distance from P to the line.
// ----------------------------------------------------------------------------
// Stages: 7 front stages, one stage per position quotient bit, one prep stage,
//   one stage per squared distance quotient bit, one per root bit, and the
//   output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, clears all valid bits; data registers are not reset.
module point_line_projection_distance_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_a_z,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_b_z,
  input  logic signed [COORD_BITS-1:0] in_p_x,
  input  logic signed [COORD_BITS-1:0] in_p_y,
  input  logic signed [COORD_BITS-1:0] in_p_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_line_position,
  output logic [COORD_BITS-2:0]        out_distance,
  output logic                         out_degenerate,
  output logic                         out_saturated
);
  import plpd_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C + 2;
  localparam int XW = 4 * C + 4;
  localparam int QP = C + 1;
  localparam int QD = 2 * C - 2;
  localparam int RW = C - 1;
  localparam int S1W = XW + PW + 3;
  localparam int S2W = C + 3 + PW;
  localparam int S3W = C + 3;

  logic      en;
  pipe_ctl_t front_ctl, pdiv_ctl, ddiv_ctl, sqrt_ctl;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front end.
  logic            f_valid, f_deg, f_nneg, f_ovf;
  logic [XW-1:0]   f_x;
  logic [PW-1:0]   f_den, f_dd, f_rem;
  logic [QP-1:0]   f_low;

  assign front_ctl = '{en: en, valid: in_valid};

  plpd_front #(.C(C), .F(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .ctl_i(front_ctl),
    .a_i({in_a_z, in_a_y, in_a_x}),
    .b_i({in_b_z, in_b_y, in_b_x}),
    .p_i({in_p_z, in_p_y, in_p_x}),
    .valid_o(f_valid), .x_o(f_x), .den_o(f_den), .dd_o(f_dd), .deg_o(f_deg),
    .nneg_o(f_nneg), .ovf_p_o(f_ovf), .rem_p_o(f_rem), .low_p_o(f_low)
  );

  // Position division.
  logic            p_valid;
  logic [QP-1:0]   p_quo;
  logic [PW-1:0]   p_rem, p_den;
  logic [S1W-1:0]  p_side;
  logic [XW-1:0]   s_x;
  logic [PW-1:0]   s_dd;
  logic            s_ovf, s_deg, s_nneg;

  assign pdiv_ctl = '{en: en, valid: f_valid};

  plpd_div #(.QW(QP), .DW(PW), .XW(S1W)) u_pdiv (
    .clk(clk), .rst_n(rst_n), .ctl_i(pdiv_ctl),
    .rem_i(f_rem), .low_i(f_low), .dvs_i(f_den),
    .side_i({f_x, f_dd, f_ovf, f_deg, f_nneg}),
    .valid_o(p_valid), .quo_o(p_quo), .rem_o(p_rem), .dvs_o(p_den), .side_o(p_side)
  );

  assign {s_x, s_dd, s_ovf, s_deg, s_nneg} = p_side;

  // Prep stage: round and saturate the position, set up the distance division.
  logic          round_up, clip;
  logic [QP:0]   qr, lim, pmag;
  logic [XW-1:0] xhi;
  logic [C-1:0]  pos_nxt;

  logic          prep_vld_r;
  logic [C-1:0]  pos_r;
  logic          satp_r, deg_r, ovfd_r;
  logic [PW-1:0] dd_r, den_r, remd_r;
  logic [QD-1:0] lowd_r;

  always_comb begin
    round_up = ({p_rem, 1'b0} >= {1'b0, p_den});
    qr       = (QP+1)'(p_quo) + (QP+1)'(round_up);
    lim      = s_nneg ? ((QP+1)'(1) << (C - 1)) : (((QP+1)'(1) << (C - 1)) - 1'b1);
    clip     = s_ovf || (qr > lim);
    pmag     = clip ? lim : qr;
    if (s_deg) begin
      pos_nxt = '0;
    end else if (s_nneg) begin
      pos_nxt = C'(-pmag);
    end else begin
      pos_nxt = C'(pmag);
    end
    xhi = s_x >> QD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= p_valid;
    end
    if (en) begin
      pos_r  <= pos_nxt;
      satp_r <= !s_deg && clip;
      deg_r  <= s_deg;
      dd_r   <= s_dd;
      den_r  <= p_den;
      ovfd_r <= (xhi >= XW'(p_den));
      remd_r <= xhi[PW-1:0];
      lowd_r <= s_x[QD-1:0];
    end
  end

  // Squared distance division.
  logic           d_valid;
  logic [QD-1:0]  d_quo;
  logic [S2W-1:0] d_side;
  logic [C-1:0]   t_pos;
  logic           t_satp, t_deg, t_ovfd;
  logic [PW-1:0]  t_dd;

  assign ddiv_ctl = '{en: en, valid: prep_vld_r};

  plpd_div #(.QW(QD), .DW(PW), .XW(S2W)) u_ddiv (
    .clk(clk), .rst_n(rst_n), .ctl_i(ddiv_ctl),
    .rem_i(remd_r), .low_i(lowd_r), .dvs_i(den_r),
    .side_i({pos_r, satp_r, deg_r, ovfd_r, dd_r}),
    .valid_o(d_valid), .quo_o(d_quo), .rem_o(), .dvs_o(), .side_o(d_side)
  );

  assign {t_pos, t_satp, t_deg, t_ovfd, t_dd} = d_side;

  // Square root; a degenerate line takes |AP|^2 directly.
  logic [QD-1:0]  rad;
  logic           satd;
  logic           r_valid;
  logic [RW-1:0]  r_root;
  logic [S3W-1:0] r_side;
  logic [C-1:0]   o_pos;
  logic           o_satp, o_deg, o_satd;

  assign rad  = t_deg ? t_dd[QD-1:0] : d_quo;
  assign satd = t_deg ? (t_dd[PW-1:QD] != '0) : t_ovfd;
  assign sqrt_ctl = '{en: en, valid: d_valid};

  plpd_sqrt #(.RW(RW), .XW(S3W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .ctl_i(sqrt_ctl),
    .rad_i(rad), .side_i({t_pos, t_satp, t_deg, satd}),
    .valid_o(r_valid), .root_o(r_root), .side_o(r_side)
  );

  assign {o_pos, o_satp, o_deg, o_satd} = r_side;

  // Output register.
  logic          out_valid_r;
  logic [C-1:0]  pos_out_r;
  logic [RW-1:0] dist_out_r;
  logic          deg_out_r, sat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r_valid;
    end
    if (en) begin
      pos_out_r  <= o_pos;
      dist_out_r <= o_satd ? '1 : r_root;
      deg_out_r  <= o_deg;
      sat_out_r  <= o_satp || o_satd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_position = $signed(pos_out_r);
  assign out_distance      = dist_out_r;
  assign out_degenerate    = deg_out_r;
  assign out_saturated     = sat_out_r;

  // A degenerate item always reports position zero.
  a_deg_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_line_position == '0)
    else $error("degenerate item with nonzero position");

  // A held pipeline keeps its result on the output.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("result lost while pipeline was held");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid result right after reset");

endmodule

// ===== rtl/plpd_front.sv =====
// ----------------------------------------------------------------------------
// plpd_front
// Seven stage front end: differences, products, sums, cross product squares
// and the operands of the position division.
// ----------------------------------------------------------------------------
module plpd_front #(
  parameter int C = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plpd_pkg::pipe_ctl_t ctl_i,
  input  logic [2:0][C-1:0]   a_i,
  input  logic [2:0][C-1:0]   b_i,
  input  logic [2:0][C-1:0]   p_i,
  output logic                valid_o,
  output logic [4*C+3:0]      x_o,
  output logic [2*C+1:0]      den_o,
  output logic [2*C+1:0]      dd_o,
  output logic                deg_o,
  output logic                nneg_o,
  output logic                ovf_p_o,
  output logic [2*C+1:0]      rem_p_o,
  output logic [C:0]          low_p_o
);
  import plpd_pkg::*;

  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int SW = PW + 2;
  localparam int NW = PW;
  localparam int MW = PW;
  localparam int H  = C + 1;
  localparam int XW = 4 * C + 4;
  localparam int QP = C + 1;
  localparam int YW = NW + F;

  logic [6:0] vld_r;

  logic signed [DW-1:0] d_r [3], d_nxt [3], e_r [3], e_nxt [3];
  logic signed [PW-1:0] pde_r [3], pde_nxt [3], pee_r [3], pee_nxt [3];
  logic signed [PW-1:0] pdd_r [3], pdd_nxt [3];
  logic signed [PW-1:0] pc1_r [3], pc1_nxt [3], pc2_r [3], pc2_nxt [3];
  logic signed [SW-1:0] num_r, num_nxt;
  logic [PW-1:0]        den_r, den_nxt, dd_r, dd_nxt;
  logic signed [PW:0]   c_r [3], c_nxt [3];
  logic [MW-1:0]        cmag_r [3], cmag_nxt [3];
  logic [2*H-1:0]       hh_r [3], hh_nxt [3], hl_r [3], hl_nxt [3], ll_r [3], ll_nxt [3];
  logic [XW-1:0]        sq_r [3], sq_nxt [3];
  logic [XW-1:0]        x_r, x_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [PW-1:0]        remp_r, remp_nxt;
  logic [QP-1:0]        lowp_r, lowp_nxt;

  // Side values carried from stage four to the end.
  logic [NW-1:0] cnmag_r [4:6], cnmag_nxt [4:6];
  logic [PW-1:0] cden_r [4:7], cden_nxt [4:7];
  logic [PW-1:0] cdd_r [4:7], cdd_nxt [4:7];
  logic          cdeg_r [4:7], cdeg_nxt [4:7];
  logic          cnneg_r [4:7], cnneg_nxt [4:7];

  logic [YW-1:0] ycat, yhi;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = DW'($signed(p_i[k])) - DW'($signed(a_i[k]));
      e_nxt[k] = DW'($signed(b_i[k])) - DW'($signed(a_i[k]));
      pde_nxt[k] = d_r[k] * e_r[k];
      pee_nxt[k] = e_r[k] * e_r[k];
      pdd_nxt[k] = d_r[k] * d_r[k];
    end
    // Cross product terms of AP and AB.
    pc1_nxt[0] = d_r[1] * e_r[2];
    pc2_nxt[0] = d_r[2] * e_r[1];
    pc1_nxt[1] = d_r[2] * e_r[0];
    pc2_nxt[1] = d_r[0] * e_r[2];
    pc1_nxt[2] = d_r[0] * e_r[1];
    pc2_nxt[2] = d_r[1] * e_r[0];

    num_nxt = SW'(pde_r[0]) + SW'(pde_r[1]) + SW'(pde_r[2]);
    den_nxt = PW'($unsigned(pee_r[0])) + PW'($unsigned(pee_r[1]))
            + PW'($unsigned(pee_r[2]));
    dd_nxt  = PW'($unsigned(pdd_r[0])) + PW'($unsigned(pdd_r[1]))
            + PW'($unsigned(pdd_r[2]));
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = (PW+1)'(pc1_r[k]) - (PW+1)'(pc2_r[k]);
      cmag_nxt[k] = c_r[k][PW] ? MW'(-c_r[k]) : MW'(c_r[k]);
      hh_nxt[k] = cmag_r[k][MW-1:H] * cmag_r[k][MW-1:H];
      hl_nxt[k] = cmag_r[k][MW-1:H] * cmag_r[k][H-1:0];
      ll_nxt[k] = cmag_r[k][H-1:0] * cmag_r[k][H-1:0];
      sq_nxt[k] = (XW'(hh_r[k]) << (2 * H)) + (XW'(hl_r[k]) << (H + 1)) + XW'(ll_r[k]);
    end

    cnmag_nxt[4] = num_r[SW-1] ? NW'(-num_r) : NW'(num_r);
    cnneg_nxt[4] = num_r[SW-1];
    cden_nxt[4]  = den_r;
    cdd_nxt[4]   = dd_r;
    cdeg_nxt[4]  = (den_r == '0);
    for (int s = 5; s <= 7; s++) begin
      cden_nxt[s]  = cden_r[s-1];
      cdd_nxt[s]   = cdd_r[s-1];
      cdeg_nxt[s]  = cdeg_r[s-1];
      cnneg_nxt[s] = cnneg_r[s-1];
    end
    cnmag_nxt[5] = cnmag_r[4];
    cnmag_nxt[6] = cnmag_r[5];

    // |AB x AP|^2, and the position dividend split at the quotient width.
    x_nxt    = sq_r[0] + sq_r[1] + sq_r[2];
    ycat     = {cnmag_r[6], {F{1'b0}}};
    yhi      = ycat >> QP;
    ovf_nxt  = (yhi >= YW'(cden_r[6]));
    remp_nxt = yhi[PW-1:0];
    lowp_nxt = ycat[QP-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl_i.en) begin
      vld_r <= {vld_r[5:0], ctl_i.valid};
    end
    if (ctl_i.en) begin
      d_r <= d_nxt;
      e_r <= e_nxt;
      pde_r <= pde_nxt;
      pee_r <= pee_nxt;
      pdd_r <= pdd_nxt;
      pc1_r <= pc1_nxt;
      pc2_r <= pc2_nxt;
      num_r <= num_nxt;
      den_r <= den_nxt;
      dd_r <= dd_nxt;
      c_r <= c_nxt;
      cmag_r <= cmag_nxt;
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      ll_r <= ll_nxt;
      sq_r <= sq_nxt;
      x_r <= x_nxt;
      ovf_r <= ovf_nxt;
      remp_r <= remp_nxt;
      lowp_r <= lowp_nxt;
      cnmag_r <= cnmag_nxt;
      cden_r <= cden_nxt;
      cdd_r <= cdd_nxt;
      cdeg_r <= cdeg_nxt;
      cnneg_r <= cnneg_nxt;
    end
  end

  assign valid_o = vld_r[6];
  assign x_o     = x_r;
  assign den_o   = cden_r[7];
  assign dd_o    = cdd_r[7];
  assign deg_o   = cdeg_r[7];
  assign nneg_o  = cnneg_r[7];
  assign ovf_p_o = ovf_r;
  assign rem_p_o = remp_r;
  assign low_p_o = lowp_r;

endmodule

// ===== rtl/plpd_div.sv =====
// ----------------------------------------------------------------------------
// plpd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module plpd_div #(
  parameter int QW = 33,
  parameter int DW = 66,
  parameter int XW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plpd_pkg::pipe_ctl_t ctl_i,
  input  logic [DW-1:0]       rem_i,
  input  logic [QW-1:0]       low_i,
  input  logic [DW-1:0]       dvs_i,
  input  logic [XW-1:0]       side_i,
  output logic                valid_o,
  output logic [QW-1:0]       quo_o,
  output logic [DW-1:0]       rem_o,
  output logic [DW-1:0]       dvs_o,
  output logic [XW-1:0]       side_o
);
  import plpd_pkg::*;

  logic          vld_r [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] qb_r [QW];
  logic [DW-1:0] dvs_r [QW];
  logic [XW-1:0] side_r [QW];

  // The user must start the remainder below the divisor (the block does not
  // check); low dividend bits leave the top of qb, quotient bits enter below.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in, dvs_in;
    logic [QW-1:0] qb_in;
    logic [XW-1:0] side_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] qb_nxt;

    if (k == 0) begin : g_src
      assign vld_in  = ctl_i.valid;
      assign rem_in  = rem_i;
      assign qb_in   = low_i;
      assign dvs_in  = dvs_i;
      assign side_in = side_i;
    end else begin : g_src
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign qb_in   = qb_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, qb_in[QW-1]};
      ge      = (trial >= {1'b0, dvs_in});
      rem_nxt = ge ? DW'(trial - {1'b0, dvs_in}) : trial[DW-1:0];
      qb_nxt  = {qb_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_in;
      end
      if (ctl_i.en) begin
        rem_r[k]  <= rem_nxt;
        qb_r[k]   <= qb_nxt;
        dvs_r[k]  <= dvs_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_r[QW-1];
  assign quo_o   = qb_r[QW-1];
  assign rem_o   = rem_r[QW-1];
  assign dvs_o   = dvs_r[QW-1];
  assign side_o  = side_r[QW-1];

endmodule

// ===== rtl/plpd_sqrt.sv =====
// ----------------------------------------------------------------------------
// plpd_sqrt
// Pipelined integer square root, one root bit per stage (floor).
// ----------------------------------------------------------------------------
module plpd_sqrt #(
  parameter int RW = 31,
  parameter int XW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plpd_pkg::pipe_ctl_t ctl_i,
  input  logic [2*RW-1:0]     rad_i,
  input  logic [XW-1:0]       side_i,
  output logic                valid_o,
  output logic [RW-1:0]       root_o,
  output logic [XW-1:0]       side_o
);
  import plpd_pkg::*;

  logic            vld_r [RW];
  logic [RW+1:0]   rem_r [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r [RW];
  logic [XW-1:0]   side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            vld_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [XW-1:0]   side_in;
    logic [RW+3:0]   trial, tr;
    logic            ge;
    logic [RW+1:0]   rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (k == 0) begin : g_src
      assign vld_in  = ctl_i.valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_src
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down two radicand bits and try 4*root+1.
    always_comb begin
      trial    = {rem_in, rad_in[2*RW-1:2*RW-2]};
      tr       = (RW+4)'({root_in, 2'b01});
      ge       = (trial >= tr);
      rem_nxt  = ge ? (RW+2)'(trial - tr) : trial[RW+1:0];
      root_nxt = {root_in[RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_in;
      end
      if (ctl_i.en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_in << 2;
        side_r[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_r[RW-1];
  assign root_o  = root_r[RW-1];
  assign side_o  = side_r[RW-1];

endmodule
